FILE: sv/gedh_pkg.sv
package gedh_pkg;

    // sizes fixed by the field widths
    localparam int CAPACITY       = 32;
    localparam int POWER_EXPONENT = 5;
    localparam int VTX_W          = 5;
    localparam int CNT_W          = 6;
    localparam int DEG_W          = 5;
    localparam int CELL_W         = 2;
    localparam int OP_W           = 3;
    localparam int SUM_W          = 30;
    localparam int HASH_W         = 29;
    localparam int POW_IDX_W      = 6;
    localparam int ROW_W          = CELL_W * CAPACITY;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 48;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);
    localparam longint unsigned SUM_MASK = (64'd1 << SUM_W) - 64'd1;

    // opcodes
    localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_VERTEX = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_MAX   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_UNKNOWN       = 2'd0;
    localparam logic [CELL_W-1:0] CELL_CONNECTED     = 2'd1;
    localparam logic [CELL_W-1:0] CELL_NOT_CONNECTED = 2'd2;

    // register indexes
    localparam logic CFG_VERTEX_LIMIT = 1'b0;
    localparam logic CFG_INIT_COUNT   = 1'b1;

    // degree power table, wrapped to the sum width
    typedef logic [(1<<POW_IDX_W)-1:0][SUM_W-1:0] pow_tab_t;

    function automatic pow_tab_t build_pow_tab();
        pow_tab_t tab;
        longint unsigned r;
        for (int d = 0; d < (1 << POW_IDX_W); d++) begin
            r = 64'd1;
            for (int k = 0; k < POWER_EXPONENT; k++) begin
                r = (r * 64'(d)) & SUM_MASK;
            end
            tab[d] = SUM_W'(r);
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    // controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             rd_a;
        logic             rd_b;
        logic             calc;
        logic             commit;
        logic             fin_b;
        logic             load_out;
        logic             clear_wr;
        logic [VTX_W-1:0] clr_addr;
    } gedh_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic restart;
    } gedh_stat_t;

endpackage

FILE: sv/graph_edge_store_degree_hash_top.sv
// channel   | direction | handshake              | payload
// s_        | in        | s_tvalid / s_tready    | s_tdata: item word
// m_        | out       | m_tvalid / m_tready    | m_tdata: result word
// cfg_      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item at a time; after accept the item steps through the row and degree
// reads, sum step, commit, second degree write and result load, and the next
// item is taken only after the load; the single-port edge row and degree memories
// set the sequence; after reset and after each initial-count write a clearing
// pass over all 32 rows runs, one edge row and degree a cycle, with no items taken
// a held result stalls the finish step until m_tready; config is always ready
module graph_edge_store_degree_hash_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[2:0], first_vertex[7:3], second_vertex[12:8], zero pad
    input  logic [gedh_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[0], hash_half[29:1], vertex_count[35:30], maximal_flag[36],
    // cell_state[38:37], first_degree[43:39], zero pad
    output logic [gedh_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [gedh_pkg::CNT_W-1:0]      cfg_data
);

    gedh_pkg::gedh_cmd_t  cmd;
    gedh_pkg::gedh_stat_t stat;

    logic                          status;
    logic [gedh_pkg::HASH_W-1:0]   hash_half;
    logic [gedh_pkg::CNT_W-1:0]    vertex_count;
    logic                          maximal_flag;
    logic [gedh_pkg::CELL_W-1:0]   cell_state;
    logic [gedh_pkg::DEG_W-1:0]    first_degree;

    assign cfg_ready = 1'b1;

    gedh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gedh_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (s_tdata[2:0]),
        .first_vertex  (s_tdata[7:3]),
        .second_vertex (s_tdata[12:8]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .hash_half     (hash_half),
        .vertex_count  (vertex_count),
        .maximal_flag  (maximal_flag),
        .cell_state    (cell_state),
        .first_degree  (first_degree)
    );

    // result word packing
    assign m_tdata = {4'b0000, first_degree, cell_state, maximal_flag,
                      vertex_count, hash_half, status};

endmodule

FILE: sv/gedh_datapath.sv
module gedh_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gedh_pkg::gedh_cmd_t          cmd,
    output gedh_pkg::gedh_stat_t         stat,
    input  logic [gedh_pkg::OP_W-1:0]    opcode,
    input  logic [gedh_pkg::VTX_W-1:0]   first_vertex,
    input  logic [gedh_pkg::VTX_W-1:0]   second_vertex,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [gedh_pkg::CNT_W-1:0]   cfg_data,
    output logic                         status,
    output logic [gedh_pkg::HASH_W-1:0]  hash_half,
    output logic [gedh_pkg::CNT_W-1:0]   vertex_count,
    output logic                         maximal_flag,
    output logic [gedh_pkg::CELL_W-1:0]  cell_state,
    output logic [gedh_pkg::DEG_W-1:0]   first_degree
);

    // edge rows hold the lower triangle: row is the larger vertex
    logic [gedh_pkg::ROW_W-1:0]  edge_mem [gedh_pkg::CAPACITY];
    logic [gedh_pkg::DEG_W-1:0]  deg_mem  [gedh_pkg::CAPACITY];

    logic [gedh_pkg::OP_W-1:0]   op_reg;
    logic [gedh_pkg::VTX_W-1:0]  a_reg;
    logic [gedh_pkg::VTX_W-1:0]  b_reg;
    logic [gedh_pkg::ROW_W-1:0]  row_rd_reg;
    logic [gedh_pkg::DEG_W-1:0]  deg_rd_reg;
    logic [gedh_pkg::DEG_W-1:0]  da_reg;
    logic [gedh_pkg::DEG_W-1:0]  db_reg;
    logic [gedh_pkg::SUM_W-1:0]  acc_reg;
    logic [gedh_pkg::SUM_W-1:0]  sum_reg;
    logic [gedh_pkg::CNT_W-1:0]  count_reg;
    logic [gedh_pkg::CNT_W-1:0]  limit_reg;
    logic                        max_reg;
    logic                        upd_reg;
    logic                        edge_ok_reg;
    logic                        status_reg;
    logic [gedh_pkg::CELL_W-1:0] cell_reg;

    logic                        status_out_reg;
    logic [gedh_pkg::HASH_W-1:0] hash_out_reg;
    logic [gedh_pkg::CNT_W-1:0]  count_out_reg;
    logic                        max_out_reg;
    logic [gedh_pkg::CELL_W-1:0] cell_out_reg;
    logic [gedh_pkg::DEG_W-1:0]  deg_out_reg;

    logic [gedh_pkg::VTX_W-1:0]  row_sel;
    logic [gedh_pkg::VTX_W-1:0]  col_sel;
    logic [gedh_pkg::CELL_W-1:0] cell_old;
    logic [gedh_pkg::ROW_W-1:0]  row_mod;
    logic                        is_connect;
    logic                        is_edge_op;
    logic                        a_ok;
    logic                        b_ok;
    logic                        pair_ok;
    logic                        status_calc;
    logic [gedh_pkg::POW_IDX_W-1:0] da_idx;
    logic [gedh_pkg::POW_IDX_W-1:0] da_step;
    logic [gedh_pkg::POW_IDX_W-1:0] db_idx;
    logic [gedh_pkg::POW_IDX_W-1:0] db_step;
    logic [gedh_pkg::DEG_W-1:0]  da_new;
    logic [gedh_pkg::DEG_W-1:0]  db_new;
    logic                        edge_we;
    logic [gedh_pkg::VTX_W-1:0]  edge_waddr;
    logic [gedh_pkg::ROW_W-1:0]  edge_wdata;
    logic                        deg_we;
    logic [gedh_pkg::VTX_W-1:0]  deg_waddr;
    logic [gedh_pkg::DEG_W-1:0]  deg_wdata;
    logic [gedh_pkg::VTX_W-1:0]  deg_raddr;
    logic [gedh_pkg::CNT_W-1:0]  init_clamped;
    logic                        a_ok_out;
    logic                        b_ok_out;

    // restart request on an initial count write
    assign stat.restart = cfg_valid && (cfg_index == gedh_pkg::CFG_INIT_COUNT);
    assign init_clamped = (cfg_data > gedh_pkg::CAP_COUNT) ? gedh_pkg::CAP_COUNT : cfg_data;

    // pair addressing
    assign row_sel  = (a_reg > b_reg) ? a_reg : b_reg;
    assign col_sel  = (a_reg > b_reg) ? b_reg : a_reg;
    assign cell_old = row_rd_reg[{col_sel, 1'b0} +: gedh_pkg::CELL_W];

    always_comb begin
        row_mod = row_rd_reg;
        row_mod[{col_sel, 1'b0} +: gedh_pkg::CELL_W] = cell_reg;
    end

    // item checks against the count before the item
    assign is_connect = (op_reg == gedh_pkg::OP_CONNECT);
    assign is_edge_op = is_connect || (op_reg == gedh_pkg::OP_DISCONNECT);
    assign a_ok       = {1'b0, a_reg} < count_reg;
    assign b_ok       = {1'b0, b_reg} < count_reg;
    assign pair_ok    = a_ok && b_ok && (a_reg != b_reg);

    always_comb begin
        case (op_reg)
            gedh_pkg::OP_CONNECT,
            gedh_pkg::OP_DISCONNECT: status_calc = !pair_ok;
            gedh_pkg::OP_ADD_VERTEX: status_calc = (count_reg >= limit_reg) ||
                                                   (count_reg >= gedh_pkg::CAP_COUNT);
            gedh_pkg::OP_MARK_MAX:   status_calc = 1'b0;
            gedh_pkg::OP_READ_CELL:  status_calc = !(a_ok && b_ok);
            default:                 status_calc = 1'b1;
        endcase
    end

    // degree step: up on connect, down on disconnect
    assign da_idx  = {1'b0, da_reg};
    assign db_idx  = {1'b0, db_reg};
    assign da_step = is_connect ? da_idx + 1'b1 : da_idx - 1'b1;
    assign db_step = is_connect ? db_idx + 1'b1 : db_idx - 1'b1;
    assign da_new  = upd_reg ? da_step[gedh_pkg::DEG_W-1:0] : da_reg;
    assign db_new  = upd_reg ? db_step[gedh_pkg::DEG_W-1:0] : db_reg;

    // edge memory port control
    assign edge_we    = cmd.clear_wr || (cmd.commit && edge_ok_reg);
    assign edge_waddr = cmd.clear_wr ? cmd.clr_addr : row_sel;
    assign edge_wdata = cmd.clear_wr ? '0 : row_mod;

    // degree memory port control
    assign deg_we    = cmd.clear_wr || ((cmd.commit || cmd.fin_b) && edge_ok_reg);
    assign deg_waddr = cmd.clear_wr ? cmd.clr_addr : (cmd.commit ? a_reg : b_reg);
    assign deg_wdata = cmd.clear_wr ? '0 : (cmd.commit ? da_new : db_new);
    assign deg_raddr = cmd.rd_b ? b_reg : a_reg;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (cmd.rd_a) begin
            row_rd_reg <= edge_mem[row_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (cmd.rd_a || cmd.rd_b) begin
            deg_rd_reg <= deg_mem[deg_raddr];
        end
    end

    // item payload and work registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= opcode;
            a_reg  <= first_vertex;
            b_reg  <= second_vertex;
        end
        if (cmd.rd_b) begin
            da_reg <= deg_rd_reg;
        end
        if (cmd.calc) begin
            db_reg      <= deg_rd_reg;
            status_reg  <= status_calc;
            edge_ok_reg <= is_edge_op && pair_ok;
            upd_reg     <= is_edge_op && pair_ok &&
                           (is_connect ? (cell_old != gedh_pkg::CELL_CONNECTED)
                                       : (cell_old == gedh_pkg::CELL_CONNECTED));
            cell_reg    <= (is_edge_op && pair_ok)
                           ? (is_connect ? gedh_pkg::CELL_CONNECTED
                                         : gedh_pkg::CELL_NOT_CONNECTED)
                           : cell_old;
            acc_reg     <= sum_reg + gedh_pkg::POW_TAB[da_step] - gedh_pkg::POW_TAB[da_idx];
        end
        if (cmd.commit) begin
            da_reg <= da_new;
        end
    end

    // graph-wide state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            limit_reg <= gedh_pkg::CAP_COUNT;
            max_reg   <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_index == gedh_pkg::CFG_VERTEX_LIMIT)) begin
                limit_reg <= cfg_data;
            end
            if (stat.restart) begin
                sum_reg   <= '0;
                count_reg <= init_clamped;
                max_reg   <= 1'b0;
            end else if (cmd.commit) begin
                if (upd_reg) begin
                    sum_reg <= acc_reg + gedh_pkg::POW_TAB[db_step]
                               - gedh_pkg::POW_TAB[db_idx];
                end
                if ((op_reg == gedh_pkg::OP_ADD_VERTEX) && !status_reg) begin
                    count_reg <= count_reg + 1'b1;
                end
                if (op_reg == gedh_pkg::OP_MARK_MAX) begin
                    max_reg <= 1'b1;
                end
            end
        end
    end

    // result word, checked against the count after the item
    assign a_ok_out = {1'b0, a_reg} < count_reg;
    assign b_ok_out = {1'b0, b_reg} < count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_out_reg <= status_reg;
            hash_out_reg   <= sum_reg[gedh_pkg::SUM_W-1:1];
            count_out_reg  <= count_reg;
            max_out_reg    <= max_reg;
            cell_out_reg   <= (a_ok_out && b_ok_out) ? cell_reg : gedh_pkg::CELL_UNKNOWN;
            deg_out_reg    <= a_ok_out ? da_reg : '0;
        end
    end

    assign status       = status_out_reg;
    assign hash_half    = hash_out_reg;
    assign vertex_count = count_out_reg;
    assign maximal_flag = max_out_reg;
    assign cell_state   = cell_out_reg;
    assign first_degree = deg_out_reg;

endmodule

FILE: sv/gedh_ctrl.sv
module gedh_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  gedh_pkg::gedh_stat_t  stat,
    output gedh_pkg::gedh_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_COMMIT,
        S_FIN_B,
        S_FIN
    } state_t;

    localparam logic [gedh_pkg::VTX_W-1:0] CLR_LAST = gedh_pkg::VTX_W'(gedh_pkg::CAPACITY - 1);

    state_t                      state_reg;
    state_t                      state_next;
    logic [gedh_pkg::VTX_W-1:0]  clr_cnt_reg;
    logic [gedh_pkg::VTX_W-1:0]  clr_cnt_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // sequencing
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.clr_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD_A;
                end
            end
            S_RD_A: begin
                cmd.rd_a   = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                cmd.rd_b   = 1'b1;
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_FIN_B;
            end
            S_FIN_B: begin
                cmd.fin_b  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        if (stat.restart) begin
            state_next   = S_CLEAR;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !stat.restart) |=> (state_reg == S_RD_A))
        else $error("accepted word did not start a read");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.restart |=> ((state_reg == S_CLEAR) && (clr_cnt_reg == '0)))
        else $error("restart did not begin a clearing pass at row zero");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input ready during clearing pass");
`endif

endmodule
